// ===== sv/cte_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cte_pkg
// Types, constants and small lookup functions shared by the calendar to
// epoch seconds pipeline.
// ----------------------------------------------------------------------------
package cte_pkg;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;
	localparam int unsigned EPOCH_W  = 38;

	localparam int unsigned Q100_W  = 8;
	localparam int unsigned Q400_W  = 6;
	localparam int unsigned NLEAP_W = 12;
	localparam int unsigned YDAY_W  = 9;
	localparam int unsigned TOD_W   = 17;
	localparam int unsigned DAYS_W  = 22;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR         = 14'd1970;
	localparam logic [YEAR_W-1:0] MAX_YEAR           = 14'd9999;
	localparam logic [YEAR_W-1:0] LEAPS_BEFORE_EPOCH = 14'd477;

	localparam int unsigned RECIP_SHIFT = 19;
	localparam logic [26:0] RECIP_100   = 27'd5243;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_DATE = 2'd1,
		ERR_TIME = 2'd2
	} cte_err_t;

	typedef struct packed {
		logic                valid;
		cte_err_t            err;
		logic [YEAR_W-1:0]   ydelta;
		logic [NLEAP_W-1:0]  nleap;
		logic [YDAY_W-1:0]   yday;
		logic [TOD_W-1:0]    tod;
	} cte_mid_t;

	// Quotient by 100 through a reciprocal; exact for every 14-bit value.
	function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] x);
		logic [26:0] pr;
		pr = 27'(x) * RECIP_100;
		return pr[RECIP_SHIFT +: Q100_W];
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [YDAY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [YDAY_W-1:0] d;
		case (m)
			4'd1:  d = 9'd0;
			4'd2:  d = 9'd31;
			4'd3:  d = 9'd59;
			4'd4:  d = 9'd90;
			4'd5:  d = 9'd120;
			4'd6:  d = 9'd151;
			4'd7:  d = 9'd181;
			4'd8:  d = 9'd212;
			4'd9:  d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cte_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cte_in_if / cte_out_if
// Valid/ready channels carrying a calendar timestamp in and epoch seconds out.
// ----------------------------------------------------------------------------
interface cte_in_if;
	logic        valid;
	logic        ready;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	modport source(output valid, output year, output month, output day,
		output hour, output minute, output second, input ready);
	modport sink(input valid, input year, input month, input day,
		input hour, input minute, input second, output ready);
endinterface

interface cte_out_if;
	logic        valid;
	logic        ready;
	logic [37:0] epoch_seconds;
	logic [1:0]  error_code;

	modport source(output valid, output epoch_seconds, output error_code,
		input ready);
	modport sink(input valid, input epoch_seconds, input error_code,
		output ready);
endinterface
`default_nettype wire

// ===== sv/cte_date.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cte_date
// First two pipeline stages: leap year quotients, date and time checks,
// leap day count, day of year and time of day in seconds.
// ----------------------------------------------------------------------------
module cte_date (
	input  wire logic         clk,
	input  wire logic         arst_n,
	cte_in_if.sink            din,
	output cte_pkg::cte_mid_t mid,
	input  wire logic         mid_ready
);
	import cte_pkg::*;

	logic en1, en2;
	logic v1_s1;
	logic v2_s2;

	logic [YEAR_W-1:0]   year_s1;
	logic [MONTH_W-1:0]  month_s1;
	logic [DAY_W-1:0]    day_s1;
	logic [HOUR_W-1:0]   hour_s1;
	logic [MINUTE_W-1:0] minute_s1;
	logic [SECOND_W-1:0] second_s1;
	logic [Q100_W-1:0]   qy_s1;
	logic [Q100_W-1:0]   qp_s1;
	logic [Q400_W-1:0]   qp4_s1;

	logic [YEAR_W-1:0] p_in;
	logic [YEAR_W-1:0] p4_in;
	logic [Q100_W-1:0] qp4_full;

	cte_mid_t mid_s2;
	cte_mid_t mid_d;

	logic [YEAR_W-1:0] p;
	logic [YEAR_W-1:0] rem100;
	logic              leap;
	logic              year_nz;
	logic              date_ok;
	logic              time_ok;
	logic [DAY_W-1:0]  len;
	logic [YEAR_W-1:0] nleap_full;
	logic [YDAY_W-1:0] yday;

	assign en2       = !v2_s2 || mid_ready;
	assign en1       = !v1_s1 || en2;
	assign din.ready = en1;

	assign p_in     = din.year - 14'd1;
	assign p4_in    = {2'd0, p_in[YEAR_W-1:2]};
	assign qp4_full = div100(p4_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && din.valid) begin
			year_s1   <= din.year;
			month_s1  <= din.month;
			day_s1    <= din.day;
			hour_s1   <= din.hour;
			minute_s1 <= din.minute;
			second_s1 <= din.second;
			qy_s1     <= div100(din.year);
			qp_s1     <= div100(p_in);
			qp4_s1    <= qp4_full[Q400_W-1:0];
		end
	end

	always_comb begin
		p          = year_s1 - 14'd1;
		rem100     = year_s1 - 14'({6'd0, qy_s1} * 14'd100);
		leap       = (year_s1[1:0] == 2'd0) && ((rem100 != 14'd0) || (qy_s1[1:0] == 2'd0));
		year_nz    = (year_s1 != 14'd0);
		len        = month_len(month_s1, leap);
		date_ok    = (year_s1 >= EPOCH_YEAR) && (year_s1 <= MAX_YEAR)
			&& (day_s1 != 5'd0) && (day_s1 <= len);
		time_ok    = (hour_s1 <= 5'd23) && (minute_s1 <= 6'd59) && (second_s1 <= 6'd59);
		nleap_full = {2'd0, p[YEAR_W-1:2]} - 14'(qp_s1) + 14'(qp4_s1) - LEAPS_BEFORE_EPOCH;
		yday       = 9'(day_s1) - 9'd1 + cum_days(month_s1)
			+ 9'((month_s1 > 4'd2) && leap);

		mid_d.valid = v1_s1;
		if (year_nz && !date_ok) begin
			mid_d.err = ERR_DATE;
		end else if (!time_ok) begin
			mid_d.err = ERR_TIME;
		end else begin
			mid_d.err = ERR_OK;
		end
		mid_d.ydelta = year_nz ? (year_s1 - EPOCH_YEAR) : '0;
		mid_d.nleap  = year_nz ? nleap_full[NLEAP_W-1:0] : '0;
		mid_d.yday   = year_nz ? yday : '0;
		mid_d.tod    = 17'(hour_s1) * 17'd3600 + 17'(minute_s1) * 17'd60 + 17'(second_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			mid_s2 <= mid_d;
		end
	end

	always_comb begin
		mid       = mid_s2;
		mid.valid = v2_s2;
	end

	a_yday_range: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && (mid_s2.err == ERR_OK) |-> (mid_s2.yday <= 9'd365))
		else $error("Day of year out of range on a valid date.");

	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && (mid_s2.err == ERR_OK) |-> (mid_s2.tod < 17'd86400))
		else $error("Time of day out of range on a checked beat.");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && !mid_ready |=> v2_s2 && $stable(mid_s2))
		else $error("Stage two beat changed while stalled.");

endmodule
`default_nettype wire

// ===== sv/cte_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cte_scale
// Last three pipeline stages: day count, scaling to seconds and the final
// sum with the time of day, ending in the output register.
// ----------------------------------------------------------------------------
module cte_scale (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cte_pkg::cte_mid_t mid,
	output logic              mid_ready,
	cte_out_if.source         dout
);
	import cte_pkg::*;

	logic en3, en4, en5;
	logic v3_s3, v4_s4, v5_s5;

	cte_err_t           err_s3, err_s4, err_s5;
	logic [TOD_W-1:0]   tod_s3, tod_s4;
	logic [DAYS_W-1:0]  days_s3;
	logic [EPOCH_W-1:0] dsec_s4;
	logic [EPOCH_W-1:0] secs_s5;

	assign en5       = !v5_s5 || dout.ready;
	assign en4       = !v4_s4 || en5;
	assign en3       = !v3_s3 || en4;
	assign mid_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (en3) begin
				v3_s3 <= mid.valid;
			end
			if (en4) begin
				v4_s4 <= v3_s3;
			end
			if (en5) begin
				v5_s5 <= v4_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && mid.valid) begin
			err_s3  <= mid.err;
			tod_s3  <= mid.tod;
			days_s3 <= 22'(mid.ydelta) * 22'd365 + 22'(mid.nleap) + 22'(mid.yday);
		end
		if (en4 && v3_s3) begin
			err_s4  <= err_s3;
			tod_s4  <= tod_s3;
			dsec_s4 <= 38'(days_s3) * 38'd86400;
		end
		if (en5 && v4_s4) begin
			err_s5  <= err_s4;
			secs_s5 <= (err_s4 == ERR_OK) ? (dsec_s4 + 38'(tod_s4)) : '0;
		end
	end

	assign dout.valid         = v5_s5;
	assign dout.epoch_seconds = secs_s5;
	assign dout.error_code    = err_s5;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v5_s5 && (err_s5 != ERR_OK) |-> (secs_s5 == '0))
		else $error("Non-zero seconds on an error beat.");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		v5_s5 |-> (err_s5 == ERR_OK || err_s5 == ERR_DATE || err_s5 == ERR_TIME))
		else $error("Undefined error code on an output beat.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v5_s5 && !dout.ready |=> v5_s5 && $stable(secs_s5) && $stable(err_s5))
		else $error("Output beat changed while the receiver stalled.");

endmodule
`default_nettype wire

// ===== sv/calendar_to_epoch_seconds.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// UTC calendar date and time of day to seconds since 1970-01-01.
//
// Each beat on din carries year, month, day, hour, minute and second. Each
// beat on dout carries epoch_seconds and error_code for one input beat, in
// the same order. A zero year gives the time of day alone. An invalid date
// reports code 1 and an invalid time of day code 2, both with zero seconds.
// The pipeline has five register stages and, while dout is not stalled,
// one beat is accepted in every cycle. The stage depth is set by the
// reciprocal dividers by 100 and the days to seconds multiplier. When dout
// is stalled the stages fill up one by one and din drops ready once all
// five hold a beat; no beat is lost or repeated. Reset empties the pipeline
// at once; no results are pending afterwards.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds (
	input wire logic clk,
	input wire logic arst_n,
	cte_in_if.sink    din,
	cte_out_if.source dout
);
	import cte_pkg::*;

	cte_mid_t mid;
	logic     mid_ready;

	cte_date u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.mid       (mid),
		.mid_ready (mid_ready)
	);

	cte_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid       (mid),
		.mid_ready (mid_ready),
		.dout      (dout)
	);

endmodule
`default_nettype wire

// ===== tb/calendar_to_epoch_seconds_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_test
// Self-checking bench for the calendar to epoch seconds pipeline. Timestamps
// go in on din; every result on dout is compared, field by field, with the
// oldest value from a local epoch calculator. The run covers corner dates and
// times first, then random well-formed dates, month ends, time-only beats,
// bad times and raw noise. It runs with no idling, with sender gaps, with
// receiver stalls, and with both at once.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_test;
	import cte_pkg::*;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned PRINT_LIMIT  = 40;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} stamp_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] seconds;
		cte_err_t           code;
	} epoch_t;

	logic clk = 1'b0;
	logic arst_n;

	cte_in_if  din();
	cte_out_if dout();

	calendar_to_epoch_seconds u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	epoch_t      pending_epochs[$];
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned mismatches;
	int unsigned stamps_sent;
	int unsigned epochs_ok;
	int unsigned epochs_bad_date;
	int unsigned epochs_bad_time;
	int unsigned quiet_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic is_leap(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11: return 30;
			2: return is_leap(y) ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned days_before_month(int unsigned y, int unsigned m);
		int unsigned total;
		total = 0;
		for (int unsigned k = 1; k < m; k++) begin
			total += days_in_month(y, k);
		end
		return total;
	endfunction

	function automatic epoch_t to_epoch(stamp_t s);
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned p;
		longint unsigned days;
		epoch_t r;
		y = s.year;
		m = s.month;
		d = s.day;
		r.seconds = '0;
		r.code = ERR_OK;
		days = 0;
		if (y != 0 && (y < EPOCH_YEAR || y > MAX_YEAR || m < 1 || m > 12 || d < 1 ||
				d > days_in_month(y, m))) begin
			r.code = ERR_DATE;
		end else if (s.hour > 23 || s.minute > 59 || s.second > 59) begin
			r.code = ERR_TIME;
		end else begin
			if (y != 0) begin
				p = y - 1;
				days = longint'(y - EPOCH_YEAR) * 365 + p / 4 - p / 100 + p / 400 -
					LEAPS_BEFORE_EPOCH + days_before_month(y, m) + d - 1;
			end
			r.seconds = EPOCH_W'(days * 86400 + longint'(s.hour) * 3600 +
				longint'(s.minute) * 60 + s.second);
		end
		return r;
	endfunction

	function automatic stamp_t make_stamp(int unsigned y, int unsigned mo, int unsigned d,
			int unsigned h, int unsigned mi, int unsigned s);
		stamp_t t;
		t.year = YEAR_W'(y);
		t.month = MONTH_W'(mo);
		t.day = DAY_W'(d);
		t.hour = HOUR_W'(h);
		t.minute = MINUTE_W'(mi);
		t.second = SECOND_W'(s);
		return t;
	endfunction

	function automatic stamp_t noise_stamp();
		return make_stamp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	function automatic int unsigned pick_year();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1970, 2100);
			1: return $urandom_range(1970, 9999);
			2: return $urandom_range(20, 99) * 100 + $urandom_range(0, 4) - 2;
			default: return $urandom_range(0, 1) ? $urandom_range(9990, 9999) :
				$urandom_range(1965, 1975);
		endcase
	endfunction

	function automatic stamp_t random_stamp();
		stamp_t t;
		int unsigned pick;
		int unsigned y;
		int unsigned m;
		pick = $urandom_range(0, 99);
		y = pick_year();
		m = $urandom_range(1, 12);
		t = make_stamp(y, m, $urandom_range(1, 31), $urandom_range(0, 23),
			$urandom_range(0, 59), $urandom_range(0, 59));
		if (pick < 55) begin
			t.day = DAY_W'($urandom_range(1, days_in_month(y, m)));
		end else if (pick < 70) begin
			// Last day of the month or the one after it, to catch leap slips.
			t.day = DAY_W'(days_in_month(y, m) + $urandom_range(0, 1));
		end else if (pick < 80) begin
			t.year = '0;
			t.month = MONTH_W'($urandom);
			t.day = DAY_W'($urandom);
		end else if (pick < 88) begin
			t.day = DAY_W'($urandom_range(1, days_in_month(y, m)));
			case ($urandom_range(0, 3))
				0: t.hour = HOUR_W'($urandom_range(24, 31));
				1: t.minute = MINUTE_W'($urandom_range(60, 63));
				2: t.second = SECOND_W'($urandom_range(60, 63));
				default: begin
					t.hour = HOUR_W'($urandom);
					t.minute = MINUTE_W'($urandom);
					t.second = SECOND_W'($urandom);
				end
			endcase
		end else begin
			t = noise_stamp();
		end
		return t;
	endfunction

	task automatic drive_fields(stamp_t s);
		din.year <= s.year;
		din.month <= s.month;
		din.day <= s.day;
		din.hour <= s.hour;
		din.minute <= s.minute;
		din.second <= s.second;
	endtask

	task automatic send_stamp(stamp_t s);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			din.valid <= 1'b0;
			drive_fields(noise_stamp());
			@(negedge clk);
		end
		din.valid <= 1'b1;
		drive_fields(s);
		do
			@(posedge clk);
		while (!din.ready);
		stamps_sent++;
	endtask

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
	endtask

	task automatic send_random_stamps(int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			send_stamp(random_stamp());
		end
	endtask

	task automatic check_corner_stamps();
		stamp_t corners[$];
		idle_pct = 0;
		stall_pct = 0;
		corners.push_back(make_stamp(1970, 1, 1, 0, 0, 0));
		corners.push_back(make_stamp(9999, 12, 31, 23, 59, 59));
		corners.push_back(make_stamp(0, 0, 0, 23, 59, 59));
		corners.push_back(make_stamp(0, 15, 31, 0, 0, 0));
		corners.push_back(make_stamp(0, 0, 0, 31, 63, 63));
		corners.push_back(make_stamp(1969, 12, 31, 23, 59, 59));
		corners.push_back(make_stamp(16383, 15, 31, 31, 63, 63));
		corners.push_back(make_stamp(10000, 1, 1, 0, 0, 0));
		corners.push_back(make_stamp(2020, 0, 1, 12, 0, 0));
		corners.push_back(make_stamp(2020, 13, 1, 12, 0, 0));
		corners.push_back(make_stamp(2020, 15, 1, 12, 0, 0));
		corners.push_back(make_stamp(2020, 6, 0, 12, 0, 0));
		corners.push_back(make_stamp(2000, 2, 29, 1, 2, 3));
		corners.push_back(make_stamp(2100, 2, 29, 1, 2, 3));
		corners.push_back(make_stamp(2100, 2, 28, 23, 59, 59));
		corners.push_back(make_stamp(2024, 2, 29, 0, 0, 1));
		corners.push_back(make_stamp(2023, 2, 29, 0, 0, 1));
		corners.push_back(make_stamp(2023, 4, 31, 0, 0, 0));
		corners.push_back(make_stamp(2023, 4, 30, 0, 0, 0));
		corners.push_back(make_stamp(1969, 1, 1, 31, 63, 63));
		corners.push_back(make_stamp(2001, 1, 1, 24, 0, 0));
		corners.push_back(make_stamp(2001, 1, 1, 0, 60, 0));
		corners.push_back(make_stamp(2001, 1, 1, 0, 0, 60));
		corners.push_back(make_stamp(2000, 12, 31, 23, 59, 59));
		corners.push_back(make_stamp(2400, 3, 1, 0, 0, 0));
		foreach (corners[i]) begin
			send_stamp(corners[i]);
		end
	endtask

	task automatic check_steady_stream();
		idle_pct = 0;
		stall_pct = 0;
		send_random_stamps(330);
	endtask

	task automatic check_sender_gaps();
		idle_pct = 61;
		stall_pct = 0;
		send_random_stamps(330);
	endtask

	task automatic check_receiver_stalls();
		idle_pct = 0;
		stall_pct = 61;
		send_random_stamps(330);
	endtask

	task automatic check_both_idle();
		idle_pct = 22;
		stall_pct = 22;
		send_random_stamps(330);
	endtask

	always @(negedge clk) begin
		dout.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Expectations are queued on the input beat before the output side is
	// looked at, so ordering never depends on process scheduling.
	always @(posedge clk) begin
		epoch_t want;
		if (arst_n && din.valid && din.ready) begin
			pending_epochs.push_back(to_epoch({din.year, din.month, din.day, din.hour,
				din.minute, din.second}));
		end
		if (arst_n && dout.valid && dout.ready) begin
			if (pending_epochs.size() == 0) begin
				report_mismatch("unexpected beat, epoch_seconds", dout.epoch_seconds, 0);
			end else begin
				want = pending_epochs.pop_front();
				if (dout.epoch_seconds !== want.seconds)
					report_mismatch("epoch_seconds", dout.epoch_seconds, want.seconds);
				if (dout.error_code !== want.code)
					report_mismatch("error_code", dout.error_code, want.code);
				case (want.code)
					ERR_OK: epochs_ok++;
					ERR_DATE: epochs_bad_date++;
					default: epochs_bad_time++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((din.valid && din.ready) || (dout.valid && dout.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timed out with %0d results outstanding.", pending_epochs.size());
				$display("calendar_to_epoch_seconds_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.year = '0;
		din.month = '0;
		din.day = '0;
		din.hour = '0;
		din.minute = '0;
		din.second = '0;
		dout.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		stamps_sent = 0;
		epochs_ok = 0;
		epochs_bad_date = 0;
		epochs_bad_time = 0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_corner_stamps();
		check_steady_stream();
		check_sender_gaps();
		check_receiver_stalls();
		check_both_idle();

		@(negedge clk);
		din.valid <= 1'b0;
		while (pending_epochs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d timestamps: %0d converted, %0d bad dates, %0d bad times.",
			stamps_sent, epochs_ok, epochs_bad_date, epochs_bad_time);
		$display("Idling phases: none, sender gaps, receiver stalls, both; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("calendar_to_epoch_seconds_test: PASS");
		end else begin
			$display("calendar_to_epoch_seconds_test: FAIL");
		end
		$finish;
	end

endmodule
